// ===== hdl/sync_length_crc32_packet_deframer_unit_assert.svh =====
// Assertion macros shared by the deframer checker
`ifndef SYNC_LENGTH_CRC32_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define SYNC_LENGTH_CRC32_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SLCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/slcd_pkg.sv =====
// Shared types, constants and CRC function of the packet deframer
package slcd_pkg;

  localparam int BYTE_W          = 8;
  localparam int CODE_W          = 16;
  localparam int CNT_W           = 3;
  localparam int SLOT_W          = 2;
  localparam int CMD_SLOTS       = 4;
  localparam int TABLE_SLOTS_DEF = 4;
  localparam int IDX_W           = 3;
  localparam int TDATA_W         = 32;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h05;
  localparam logic [CODE_W-1:0] MIN_LEN   = 16'd4;
  localparam logic [15:0]       CRC_BYTES = 16'd4;
  localparam logic [31:0]       CRC_POLY  = 32'hEDB88320;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CMD_0     = 3'd0;
  localparam logic [IDX_W-1:0] REG_CMD_1     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CMD_2     = 3'd2;
  localparam logic [IDX_W-1:0] REG_CMD_3     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CMD_COUNT = 3'd4;
  localparam logic [IDX_W-1:0] REG_CRC_ORDER = 3'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSYNC  = 2'd1,
    ST_CORRUPT = 2'd2,
    ST_NOTREG  = 2'd3
  } slcd_status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [CMD_SLOTS-1:0][CODE_W-1:0] code;
    logic [CNT_W-1:0]                 count;
    logic                             crc_msb_first;
  } slcd_cfg_t;

  typedef struct packed {
    logic init;
    logic update;
    logic take_rx;
    logic msb_first;
  } slcd_crc_ctl_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [BYTE_W-1:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/sync_length_crc32_packet_deframer_unit.sv =====
// Sync / length / CRC-32 packet deframer, top level
// Usage:
//   s_* carries received bytes, one per beat, in s_tdata[7:0].
//   m_* carries results: m_tuser 0 is a payload byte, 1 a packet verdict;
//   m_tlast marks every verdict. A frame is sync 0x05, 16-bit big-endian
//   length (counts length, command and payload bytes), 16-bit command,
//   payload, then four CRC-32 bytes. Payload bytes go out as they arrive;
//   the last CRC byte gives ok (with table slot), corrupt or not registered.
//   A run of junk while hunting gives a single nosync verdict.
//   cfg_* writes the command table, slot count and CRC byte order; write it
//   only while no bytes are in flight.
// Timing: an accepted byte is held in the input register; its result, if any,
//   is registered into the output register. One input register and one output
//   register; the byte-wide CRC step and table compare sit between them, so
//   one byte per cycle is sustained while m_tready stays high.
// Reset (rst, synchronous): block hunts for sync, output empty, table clear,
//   CRC order MSB first. While m_tready is low and m_* holds a beat, the output
//   register holds and at most one more byte is taken into the input register.
module sync_length_crc32_packet_deframer_unit #(
  parameter int TABLE_SLOTS = slcd_pkg::TABLE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [slcd_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [7:0] payload_byte, [9:8] status, [11:10] slot_index, [27:12] command_code
  output logic [slcd_pkg::TDATA_W-1:0] m_tdata,
  output logic                         m_tuser,   // [0] kind
  output logic                         m_tlast,   // frame_end
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [slcd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [slcd_pkg::CODE_W-1:0]  cfg_data
);
  import slcd_pkg::*;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_LEN_HI  = 7'b0000010,
    PH_LEN_LO  = 7'b0000100,
    PH_CMD_HI  = 7'b0001000,
    PH_CMD_LO  = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_CRC     = 7'b1000000
  } phase_t;

  slcd_cfg_t     cfg;
  slcd_crc_ctl_t crc_ctl;
  logic          crc_ok;
  logic          hit;
  logic [SLOT_W-1:0] hit_slot;

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              adv;

  // frame state
  phase_t        phase, phase_next;
  logic          junk_reported, junk_reported_next;
  logic [15:0]   byte_count, byte_count_next;
  logic [15:0]   frame_length, frame_length_next;
  logic [CODE_W-1:0] command_reg, command_reg_next;

  // result
  logic              emit;
  logic              res_kind;
  logic [BYTE_W-1:0] res_pay;
  slcd_status_t      res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [CODE_W-1:0] res_cmd;
  logic              res_end;

  logic [15:0]   count_inc;
  logic [15:0]   len_lo_value;
  slcd_crc_ctl_t ctl_raw;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || adv;

  slcd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign crc_ctl = adv ? ctl_raw : '{init: 1'b0, update: 1'b0, take_rx: 1'b0,
                                     msb_first: cfg.crc_msb_first};

  slcd_crc u_crc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (crc_ctl),
    .rx_byte (in_byte),
    .crc_ok  (crc_ok)
  );

  slcd_cmd_match #(.TABLE_SLOTS(TABLE_SLOTS)) u_match (
    .cfg     (cfg),
    .command (command_reg),
    .hit     (hit),
    .slot    (hit_slot)
  );

  assign count_inc    = byte_count + 16'd1;
  assign len_lo_value = {frame_length[15:8], in_byte};

  always_comb begin
    phase_next         = phase;
    junk_reported_next = junk_reported;
    byte_count_next    = byte_count;
    frame_length_next  = frame_length;
    command_reg_next   = command_reg;
    ctl_raw            = '{init: 1'b0, update: 1'b0, take_rx: 1'b0,
                           msb_first: cfg.crc_msb_first};
    emit       = 1'b0;
    res_kind   = KIND_VERDICT;
    res_pay    = '0;
    res_status = ST_OK;
    res_slot   = '0;
    res_cmd    = '0;
    res_end    = 1'b1;
    unique case (phase)
      PH_HUNT: begin
        if (in_byte == SYNC_BYTE) begin
          junk_reported_next = 1'b0;
          ctl_raw.init       = 1'b1;
          byte_count_next    = '0;
          frame_length_next  = '0;
          command_reg_next   = '0;
          phase_next         = PH_LEN_HI;
        end else if (!junk_reported) begin
          junk_reported_next = 1'b1;
          emit               = 1'b1;
          res_status         = ST_NOSYNC;
        end
      end
      PH_LEN_HI: begin
        ctl_raw.update    = 1'b1;
        frame_length_next = {in_byte, 8'h00};
        byte_count_next   = 16'd1;
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        ctl_raw.update    = 1'b1;
        frame_length_next = len_lo_value;
        byte_count_next   = 16'd2;
        if (len_lo_value < MIN_LEN) begin
          // too short to hold a command: drop at once
          phase_next = PH_HUNT;
          emit       = 1'b1;
          res_status = ST_CORRUPT;
        end else begin
          phase_next = PH_CMD_HI;
        end
      end
      PH_CMD_HI: begin
        ctl_raw.update   = 1'b1;
        command_reg_next = {in_byte, 8'h00};
        byte_count_next  = 16'd3;
        phase_next       = PH_CMD_LO;
      end
      PH_CMD_LO: begin
        ctl_raw.update   = 1'b1;
        command_reg_next = {command_reg[15:8], in_byte};
        if (frame_length == MIN_LEN) begin
          byte_count_next = '0;
          phase_next      = PH_CRC;
        end else begin
          byte_count_next = 16'd4;
          phase_next      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ctl_raw.update = 1'b1;
        if (count_inc >= frame_length) begin
          byte_count_next = '0;
          phase_next      = PH_CRC;
        end else begin
          byte_count_next = count_inc;
        end
        emit     = 1'b1;
        res_kind = KIND_PAYLOAD;
        res_pay  = in_byte;
        res_end  = 1'b0;
      end
      PH_CRC: begin
        ctl_raw.take_rx = 1'b1;
        if (count_inc < CRC_BYTES) begin
          byte_count_next = count_inc;
        end else begin
          byte_count_next = '0;
          phase_next      = PH_HUNT;
          emit            = 1'b1;
          res_cmd         = command_reg;
          if (!crc_ok) begin
            res_status = ST_CORRUPT;
          end else if (hit) begin
            res_status = ST_OK;
            res_slot   = hit_slot;
          end else begin
            res_status = ST_NOTREG;
          end
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      phase         <= PH_HUNT;
      junk_reported <= 1'b0;
      byte_count    <= '0;
      frame_length  <= '0;
      command_reg   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (adv) begin
        in_valid <= 1'b0;
      end
      if (adv) begin
        phase         <= phase_next;
        junk_reported <= junk_reported_next;
        byte_count    <= byte_count_next;
        frame_length  <= frame_length_next;
        command_reg   <= command_reg_next;
        m_tvalid      <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (adv && emit) begin
      m_tdata <= {(TDATA_W - CODE_W - 2 * SLOT_W - BYTE_W)'(0), res_cmd, res_slot,
                  res_status, res_pay};
      m_tuser <= res_kind;
      m_tlast <= res_end;
    end
  end

endmodule

// ===== hdl/slcd_cfg_regs.sv =====
// Configuration register file of the packet deframer
module slcd_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [slcd_pkg::IDX_W-1:0]  wr_index,
  input  logic [slcd_pkg::CODE_W-1:0] wr_data,
  output slcd_pkg::slcd_cfg_t       cfg
);
  import slcd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code          <= '0;
      cfg.count         <= '0;
      cfg.crc_msb_first <= 1'b1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CMD_0:     cfg.code[0]       <= wr_data;
        REG_CMD_1:     cfg.code[1]       <= wr_data;
        REG_CMD_2:     cfg.code[2]       <= wr_data;
        REG_CMD_3:     cfg.code[3]       <= wr_data;
        REG_CMD_COUNT: cfg.count         <= wr_data[CNT_W-1:0];
        REG_CRC_ORDER: cfg.crc_msb_first <= wr_data[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

// ===== hdl/slcd_crc.sv =====
// CRC-32 accumulator and received-CRC shifter
module slcd_crc (
  input  logic                      clk,
  input  logic                      rst,
  input  slcd_pkg::slcd_crc_ctl_t   ctl,
  input  logic [slcd_pkg::BYTE_W-1:0] rx_byte,
  output logic                      crc_ok
);
  import slcd_pkg::*;

  logic [31:0] crc_accum;
  logic [31:0] crc_received;
  logic [31:0] crc_received_next;

  assign crc_received_next = ctl.msb_first ? {crc_received[23:0], rx_byte}
                                           : {rx_byte, crc_received[31:8]};

  // compare includes the byte now arriving
  assign crc_ok = (~crc_accum == crc_received_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum    <= '1;
      crc_received <= '0;
    end else if (ctl.init) begin
      crc_accum    <= '1;
      crc_received <= '0;
    end else begin
      if (ctl.update)  crc_accum    <= crc32_byte(crc_accum, rx_byte);
      if (ctl.take_rx) crc_received <= crc_received_next;
    end
  end

endmodule

// ===== hdl/slcd_cmd_match.sv =====
// Combinational lookup in the table of registered commands, lowest matching slot wins
module slcd_cmd_match #(
  parameter int TABLE_SLOTS = slcd_pkg::TABLE_SLOTS_DEF
) (
  input  slcd_pkg::slcd_cfg_t         cfg,
  input  logic [slcd_pkg::CODE_W-1:0] command,
  output logic                        hit,
  output logic [slcd_pkg::SLOT_W-1:0] slot
);
  import slcd_pkg::*;

  logic [CNT_W-1:0] lim;

  assign lim = (cfg.count > CNT_W'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS) : cfg.count;

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < lim) && (cfg.code[i] == command)) begin
        hit  = 1'b1;
        slot = SLOT_W'(i);
      end
    end
  end

endmodule

// ===== hdl/slcd_checker.sv =====
// Port-level checker for the packet deframer, bound to the top level
`include "sync_length_crc32_packet_deframer_unit_assert.svh"

module slcd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [slcd_pkg::TDATA_W-1:0] m_tdata,
  input logic                         m_tuser,
  input logic                         m_tlast
);
  import slcd_pkg::*;

  `SLCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
  `SLCD_ASSERT_NOW(a_payload_clean, m_tvalid && (m_tuser == KIND_PAYLOAD), !m_tlast && (m_tdata[27:8] == 20'h0), "payload beat carries verdict fields")
  `SLCD_ASSERT_NOW(a_verdict_clean, m_tvalid && (m_tuser == KIND_VERDICT), m_tlast && (m_tdata[7:0] == 8'h0), "verdict beat malformed")
  `SLCD_ASSERT_NOW(a_slot_only_ok, m_tvalid && (m_tdata[9:8] != ST_OK), (m_tdata[11:10] == 2'd0) && ((m_tdata[9:8] != ST_NOSYNC) || (m_tdata[27:12] == 16'h0)), "slot or command set on non-ok verdict")

endmodule

bind sync_length_crc32_packet_deframer_unit slcd_checker u_slcd_checker (.*);

// ===== test/sync_length_crc32_packet_deframer_unit_tb.sv =====
// Self-checking bench for the sync/length/CRC-32 packet deframer: directed rows, then random frames
`timescale 1ns / 100ps

module sync_length_crc32_packet_deframer_unit_tb;
  import slcd_pkg::*;

  typedef enum logic [2:0] {
    P_HUNT, P_LEN_HI, P_LEN_LO, P_CMD_HI, P_CMD_LO, P_PAYLOAD, P_CRC
  } rx_phase_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   pay;
    slcd_status_t status;
    logic [1:0]   slot;
    logic [15:0]  cmd;
    logic         fend;
  } frame_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       use_fcs;  // send the correct CRC byte for this position
    logic       typed;    // res holds the expected result
    frame_res_t res;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [CODE_W-1:0]   cfg_data;

  sync_length_crc32_packet_deframer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and deframer state
  logic [15:0] tbl_code [CMD_SLOTS];
  logic [2:0]  tbl_count;
  logic        rx_msb_first;
  rx_phase_t   pr_phase;
  logic        pr_junk;
  logic [15:0] pr_cnt;
  logic [15:0] pr_len;
  logic [15:0] pr_cmd;
  logic [31:0] pr_crc;
  logic [31:0] pr_rxcrc;

  frame_res_t pending_res [$];
  dir_row_t   dir_tab [$];
  int         bad_count;
  int         busy_beats;
  int         src_idle_pct;
  int         snk_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic frame_res_t mk_res(logic kind, logic [7:0] pay, slcd_status_t st,
                                        logic [1:0] slot, logic [15:0] cmd, logic fend);
    frame_res_t r;
    r.kind = kind;
    r.pay = pay;
    r.status = st;
    r.slot = slot;
    r.cmd = cmd;
    r.fend = fend;
    return r;
  endfunction

  function automatic dir_row_t drow(logic [7:0] b, logic use_fcs, logic typed, frame_res_t r);
    dir_row_t d;
    d.b = b;
    d.use_fcs = use_fcs;
    d.typed = typed;
    d.res = r;
    return d;
  endfunction

  // reflected CRC-32, input bits fed LSB first
  function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // correct CRC byte for the next position of the trailer
  function automatic logic [7:0] fcs_byte();
    logic [31:0] f;
    f = ~pr_crc;
    if (rx_msb_first) return 8'(f >> (8 * (3 - pr_cnt)));
    return 8'(f >> (8 * pr_cnt));
  endfunction

  function automatic bit deframe_step(input logic [7:0] b, output frame_res_t r);
    int lim;
    r = '0;
    case (pr_phase)
      P_HUNT: begin
        if (b == SYNC_BYTE) begin
          pr_junk = 1'b0;
          pr_crc = 32'hFFFF_FFFF;
          pr_rxcrc = '0;
          pr_cnt = '0;
          pr_len = '0;
          pr_cmd = '0;
          pr_phase = P_LEN_HI;
          return 1'b0;
        end
        if (!pr_junk) begin
          pr_junk = 1'b1;
          r = mk_res(KIND_VERDICT, 8'h00, ST_NOSYNC, 2'd0, 16'h0000, 1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
      P_LEN_HI: begin
        pr_crc = crc_update(pr_crc, b);
        pr_len = {b, 8'h00};
        pr_cnt = 16'd1;
        pr_phase = P_LEN_LO;
        return 1'b0;
      end
      P_LEN_LO: begin
        pr_crc = crc_update(pr_crc, b);
        pr_len[7:0] = b;
        pr_cnt = 16'd2;
        if (pr_len < MIN_LEN) begin
          pr_phase = P_HUNT;
          r = mk_res(KIND_VERDICT, 8'h00, ST_CORRUPT, 2'd0, 16'h0000, 1'b1);
          return 1'b1;
        end
        pr_phase = P_CMD_HI;
        return 1'b0;
      end
      P_CMD_HI: begin
        pr_crc = crc_update(pr_crc, b);
        pr_cmd = {b, 8'h00};
        pr_cnt = 16'd3;
        pr_phase = P_CMD_LO;
        return 1'b0;
      end
      P_CMD_LO: begin
        pr_crc = crc_update(pr_crc, b);
        pr_cmd[7:0] = b;
        pr_cnt = 16'd4;
        if (pr_len == MIN_LEN) begin
          pr_cnt = '0;
          pr_phase = P_CRC;
        end else begin
          pr_phase = P_PAYLOAD;
        end
        return 1'b0;
      end
      P_PAYLOAD: begin
        pr_crc = crc_update(pr_crc, b);
        pr_cnt = pr_cnt + 16'd1;
        if (pr_cnt >= pr_len) begin
          pr_cnt = '0;
          pr_phase = P_CRC;
        end
        r = mk_res(KIND_PAYLOAD, b, ST_OK, 2'd0, 16'h0000, 1'b0);
        return 1'b1;
      end
      P_CRC: begin
        if (rx_msb_first) pr_rxcrc = {pr_rxcrc[23:0], b};
        else pr_rxcrc = {b, pr_rxcrc[31:8]};
        pr_cnt = pr_cnt + 16'd1;
        if (pr_cnt < CRC_BYTES) return 1'b0;
        pr_phase = P_HUNT;
        pr_cnt = '0;
        if (~pr_crc != pr_rxcrc) begin
          r = mk_res(KIND_VERDICT, 8'h00, ST_CORRUPT, 2'd0, pr_cmd, 1'b1);
          return 1'b1;
        end
        lim = (tbl_count > CMD_SLOTS) ? CMD_SLOTS : int'(tbl_count);
        for (int i = 0; i < lim; i++) begin
          if (tbl_code[i] == pr_cmd) begin
            r = mk_res(KIND_VERDICT, 8'h00, ST_OK, 2'(i), pr_cmd, 1'b1);
            return 1'b1;
          end
        end
        r = mk_res(KIND_VERDICT, 8'h00, ST_NOTREG, 2'd0, pr_cmd, 1'b1);
        return 1'b1;
      end
      default: begin
        pr_phase = P_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  // one input beat: optional gap, hold until accepted, then predict
  task automatic send_beat(input logic [7:0] b, input logic typed = 1'b0,
                           input frame_res_t tres = '0);
    frame_res_t r;
    bit         has;
    @(negedge clk);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    do @(posedge clk); while (!s_tready);
    // repeated junk while hunting is ignored by the block
    if (!(pr_phase == P_HUNT && pr_junk && b != SYNC_BYTE)) busy_beats++;
    has = deframe_step(b, r);
    if (typed) pending_res.push_back(tres);
    else if (has) pending_res.push_back(r);
  endtask

  // stop sending, let every expected result arrive, then cover the pipeline
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_setting(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [15:0] c2, input logic [15:0] c3,
                              input logic [2:0] cnt, input logic msb);
    logic [15:0]      val [6];
    logic [IDX_W-1:0] reg_idx [6];
    val = '{c0, c1, c2, c3, {13'd0, cnt}, {15'd0, msb}};
    reg_idx = '{REG_CMD_0, REG_CMD_1, REG_CMD_2, REG_CMD_3, REG_CMD_COUNT, REG_CRC_ORDER};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_valid = 1'b1;
      cfg_index = reg_idx[i];
      cfg_data = val[i];
      do @(posedge clk); while (!cfg_ready);
      case (reg_idx[i])
        REG_CMD_0:     tbl_code[0] = val[i];
        REG_CMD_1:     tbl_code[1] = val[i];
        REG_CMD_2:     tbl_code[2] = val[i];
        REG_CMD_3:     tbl_code[3] = val[i];
        REG_CMD_COUNT: tbl_count = val[i][2:0];
        REG_CRC_ORDER: rx_msb_first = val[i][0];
        default: ;
      endcase
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_frame();
    logic [15:0] code;
    logic [15:0] flen;
    logic [7:0]  b;
    int          plen;
    bit          bad;
    int          bad_pos;
    code = ($urandom_range(0, 9) < 6) ? tbl_code[$urandom_range(0, 3)] : 16'($urandom);
    plen = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
    flen = 16'(plen + 4);
    bad = ($urandom_range(0, 4) == 0);
    bad_pos = $urandom_range(0, 3);
    send_beat(SYNC_BYTE);
    send_beat(flen[15:8]);
    send_beat(flen[7:0]);
    send_beat(code[15:8]);
    send_beat(code[7:0]);
    for (int i = 0; i < plen; i++) send_beat(8'($urandom_range(0, 255)));
    for (int k = 0; k < 4; k++) begin
      b = fcs_byte();
      if (bad && k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      send_beat(b);
    end
  endtask

  task automatic send_noise();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_BYTE) b = b ^ 8'h01;
        send_beat(b);
      end
    end else begin
      send_beat(SYNC_BYTE);
      send_beat(8'h00);
      send_beat(8'($urandom_range(0, 3)));
    end
  endtask

  // result sink with random stall bursts
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < snk_idle_pct) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_res_t want;
    frame_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[11:10], m_tdata[27:12], m_tlast};
      if (pending_res.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result beat: kind=%b pay=%h st=%0d slot=%0d cmd=%h end=%b",
                   got.kind, got.pay, got.status, got.slot, got.cmd, got.fend);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          bad_count++;
          if (bad_count <= 10)
            $display("result mismatch: exp kind=%b pay=%h st=%0d slot=%0d cmd=%h end=%b, got kind=%b pay=%h st=%0d slot=%0d cmd=%h end=%b",
                     want.kind, want.pay, want.status, want.slot, want.cmd, want.fend,
                     got.kind, got.pay, got.status, got.slot, got.cmd, got.fend);
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    logic [7:0] b;
    int target;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CMD_0;
    cfg_data = '0;
    bad_count = 0;
    busy_beats = 0;
    src_idle_pct = 15;
    snk_idle_pct = 10;
    for (int i = 0; i < CMD_SLOTS; i++) tbl_code[i] = '0;
    tbl_count = '0;
    rx_msb_first = 1'b1;
    pr_phase = P_HUNT;
    pr_junk = 1'b0;
    pr_cnt = '0;
    pr_len = '0;
    pr_cmd = '0;
    pr_crc = 32'hFFFF_FFFF;
    pr_rxcrc = '0;

    // reset table: no registered codes, CRC MSB first
    dir_tab.push_back(drow(8'hFF, 1'b0, 1'b1,
                           mk_res(KIND_VERDICT, 8'h00, ST_NOSYNC, 2'd0, 16'h0000, 1'b1)));
    dir_tab.push_back(drow(8'h00, 1'b0, 1'b0, '0));      // same junk run, no verdict
    dir_tab.push_back(drow(SYNC_BYTE, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h00, 1'b0, 1'b1,            // length zero
                           mk_res(KIND_VERDICT, 8'h00, ST_CORRUPT, 2'd0, 16'h0000, 1'b1)));
    dir_tab.push_back(drow(SYNC_BYTE, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h04, 1'b0, 1'b0, '0));      // no payload
    dir_tab.push_back(drow(8'hFF, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'hFF, 1'b0, 1'b0, '0));
    repeat (4) dir_tab.push_back(drow(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(SYNC_BYTE, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h06, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(drow(8'h00, 1'b0, 1'b1,
                           mk_res(KIND_PAYLOAD, 8'h00, ST_OK, 2'd0, 16'h0000, 1'b0)));
    dir_tab.push_back(drow(8'hFF, 1'b0, 1'b1,
                           mk_res(KIND_PAYLOAD, 8'hFF, ST_OK, 2'd0, 16'h0000, 1'b0)));
    repeat (3) dir_tab.push_back(drow(8'h00, 1'b1, 1'b0, '0));
    dir_tab.push_back(drow(8'h00, 1'b1, 1'b1,            // good CRC, empty table
                           mk_res(KIND_VERDICT, 8'h00, ST_NOTREG, 2'd0, 16'h0000, 1'b1)));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      b = row.use_fcs ? fcs_byte() : row.b;
      send_beat(b, row.typed, row.res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      // sender holds off until every result is back before each setting
      settle();
      case (ph)
        0: load_setting(16'h0000, 16'hFFFF, 16'h1234, 16'h1234, 3'd4, 1'b1);
        1: load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        3'd7, 1'b0);
        2: load_setting(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 3'd0, 1'b1);
        3: load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        3'($urandom_range(1, 3)), 1'b0);
        4: load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        3'd5, 1'b1);
        default: load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              3'd4, 1'($urandom_range(0, 1)));
      endcase
      src_idle_pct = (ph >= 4) ? 0 : 15;
      snk_idle_pct = (ph == 5) ? 0 : 10;
      target = busy_beats + 305;
      while (busy_beats < target) begin
        if ($urandom_range(0, 9) < 8) send_frame();
        else send_noise();
      end
    end

    settle();
    if (bad_count == 0 && pending_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
